/* hw/rtl/hfcs_pkg.sv */
package hfcs_pkg;

    // Frame kind codes as carried on the result tuser.
    typedef enum logic [1:0] {
        KIND_SQUITTER = 2'd0,
        KIND_DOWNLINK = 2'd1,
        KIND_UPLINK   = 2'd2
    } frame_kind_t;

    // Check status codes as carried in the low bits of the result tdata.
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_FCS_FAIL = 2'd1,
        STATUS_SHORT    = 2'd2
    } check_status_t;

    // Reflected CRC-16 (HDLC / X.25).
    localparam logic [15:0] FCS_INIT = 16'hFFFF;
    localparam logic [15:0] FCS_POLY = 16'h8408;

    // Squitter geometry.
    localparam logic [7:0] SQ_HDR_LEN   = 8'd64;
    localparam logic [8:0] SQ_FRAME_LEN = 9'd66;

    // Downlink header base length before the LPDU entries.
    localparam logic [7:0] DL_HDR_BASE = 8'd6;
    // Uplink header prefix and per-block base length.
    localparam logic [7:0] UL_HDR_BASE = 8'd2;
    localparam logic [7:0] UL_BLK_BASE = 8'd2;

    // Byte position counter saturation value.
    localparam logic [7:0] POS_MAX = 8'd255;

endpackage

/* hw/rtl/hfdl_header_fcs_checker.sv */
// Channel   Dir  tdata (low bit first)                                    tuser       tlast
// s_axis    in   frame_byte[7:0]                                          -           end_of_frame
// m_axis    out  check_status[1:0] station_id[8:2] aircraft_id[16:9]      frame_kind  -
//                unit_count[20:17] header_bytes[28:21] zero[31:29]
//
// One byte is accepted per cycle with no gaps between frames, unless a held result stalls the input.
// A byte is held in the input register and is then folded into the header
// state and the byte-wide CRC update; a frame's last byte then loads the result register.
// A held result stalls the input only when the next processed byte is also a last byte.
// Reset is asynchronous and active low; it clears all frame state and empties both stages.
module hfdl_header_fcs_checker
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // frame_byte[7:0]
    input  logic        s_axis_tlast,   // end_of_frame

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // check_status, station_id, aircraft_id,
                                        // unit_count, header_bytes, zero padding
    output logic [1:0]  m_axis_tuser    // frame_kind
);

    // Input register.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Frame state.
    logic [7:0]                pos_reg, pos_next;
    hfcs_pkg::frame_kind_t     kind_reg, kind_next;
    logic [7:0]                hend_reg, hend_next;
    logic [3:0]                blocks_reg, blocks_next;
    logic [15:0]               crc_reg, crc_next;
    logic [15:0]               fcs_reg, fcs_next;
    logic [6:0]                station_reg, station_next;
    logic [7:0]                aircraft_reg, aircraft_next;
    logic [3:0]                count_reg, count_next;
    logic                      known_reg, known_next;

    // Result register.
    logic                      out_valid_reg;
    hfcs_pkg::frame_kind_t     out_kind_reg;
    hfcs_pkg::check_status_t   out_status_reg, status_next;
    logic [6:0]                out_station_reg;
    logic [7:0]                out_aircraft_reg;
    logic [3:0]                out_count_reg;
    logic [7:0]                out_hend_reg;

    logic        out_free;
    logic        stage_go;
    logic        stage_fire;
    logic [15:0] crc_upd;
    logic [8:0]  frame_len;

    // Handshake: the processing stage moves unless it must emit into a held result.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign stage_go      = !in_last_reg || out_free;
    assign stage_fire    = in_valid_reg && stage_go;
    assign s_axis_tready = !in_valid_reg || stage_go;

    hfcs_crc16_byte u_crc
    (
        .crc_in  (crc_reg),
        .data_in (in_byte_reg),
        .crc_out (crc_upd)
    );

    // Header tracking, CRC and FCS capture for the byte in the input register.
    always_comb
    begin
        kind_next     = kind_reg;
        hend_next     = hend_reg;
        blocks_next   = blocks_reg;
        crc_next      = crc_reg;
        fcs_next      = fcs_reg;
        station_next  = station_reg;
        aircraft_next = aircraft_reg;
        count_next    = count_reg;
        known_next    = known_reg;

        // The first byte classifies the frame.
        if (pos_reg == 8'd0)
        begin
            if (!in_byte_reg[0])
            begin
                kind_next  = hfcs_pkg::KIND_SQUITTER;
                hend_next  = hfcs_pkg::SQ_HDR_LEN;
                count_next = 4'd0;
                known_next = 1'b1;
            end
            else if (in_byte_reg[1])
            begin
                kind_next  = hfcs_pkg::KIND_DOWNLINK;
                count_next = in_byte_reg[5:2];
                hend_next  = hfcs_pkg::DL_HDR_BASE + {4'd0, in_byte_reg[5:2]};
                known_next = 1'b1;
            end
            else
            begin
                kind_next   = hfcs_pkg::KIND_UPLINK;
                count_next  = {1'b0, in_byte_reg[6:4]} + 4'd1;
                blocks_next = {1'b0, in_byte_reg[6:4]} + 4'd1;
                hend_next   = hfcs_pkg::UL_HDR_BASE;
                known_next  = 1'b0;
            end
        end
        if (pos_reg == 8'd1)
        begin
            station_next = in_byte_reg[6:0];
        end
        if (pos_reg == 8'd2 && kind_next == hfcs_pkg::KIND_DOWNLINK)
        begin
            aircraft_next = in_byte_reg;
        end

        // Header bytes feed the CRC; uplink block lengths extend the header.
        if (!known_next || pos_reg < hend_next)
        begin
            crc_next = crc_upd;
            if (!known_next && {1'b0, pos_reg} == {1'b0, hend_next} + 9'd1
                && blocks_next != 4'd0)
            begin
                hend_next   = hend_next + hfcs_pkg::UL_BLK_BASE + {4'd0, in_byte_reg[7:4]};
                blocks_next = blocks_next - 4'd1;
                if (blocks_next == 4'd0)
                begin
                    known_next = 1'b1;
                end
            end
        end
        else if (pos_reg == hend_next)
        begin
            fcs_next = {fcs_reg[15:8], in_byte_reg};
        end
        else if ({1'b0, pos_reg} == {1'b0, hend_next} + 9'd1)
        begin
            fcs_next = {in_byte_reg, fcs_reg[7:0]};
        end

        // Saturating byte position.
        pos_next = (pos_reg != hfcs_pkg::POS_MAX) ? pos_reg + 8'd1 : pos_reg;
    end

    // Status of the frame as it stands after this byte.
    assign frame_len = {1'b0, pos_reg} + 9'd1;

    always_comb
    begin
        if (!known_next || frame_len < {1'b0, hend_next} + 9'd2
            || (kind_next == hfcs_pkg::KIND_SQUITTER && frame_len < hfcs_pkg::SQ_FRAME_LEN))
        begin
            status_next = hfcs_pkg::STATUS_SHORT;
        end
        else if ((crc_next ^ hfcs_pkg::FCS_INIT) == fcs_next)
        begin
            status_next = hfcs_pkg::STATUS_OK;
        end
        else
        begin
            status_next = hfcs_pkg::STATUS_FCS_FAIL;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // Frame state; a last byte rearms it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= 8'd0;
            kind_reg     <= hfcs_pkg::KIND_SQUITTER;
            hend_reg     <= 8'd0;
            blocks_reg   <= 4'd0;
            crc_reg      <= hfcs_pkg::FCS_INIT;
            fcs_reg      <= 16'd0;
            station_reg  <= 7'd0;
            aircraft_reg <= 8'd0;
            count_reg    <= 4'd0;
            known_reg    <= 1'b0;
        end
        else if (stage_fire)
        begin
            if (in_last_reg)
            begin
                pos_reg      <= 8'd0;
                kind_reg     <= hfcs_pkg::KIND_SQUITTER;
                hend_reg     <= 8'd0;
                blocks_reg   <= 4'd0;
                crc_reg      <= hfcs_pkg::FCS_INIT;
                fcs_reg      <= 16'd0;
                station_reg  <= 7'd0;
                aircraft_reg <= 8'd0;
                count_reg    <= 4'd0;
                known_reg    <= 1'b0;
            end
            else
            begin
                pos_reg      <= pos_next;
                kind_reg     <= kind_next;
                hend_reg     <= hend_next;
                blocks_reg   <= blocks_next;
                crc_reg      <= crc_next;
                fcs_reg      <= fcs_next;
                station_reg  <= station_next;
                aircraft_reg <= aircraft_next;
                count_reg    <= count_next;
                known_reg    <= known_next;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= stage_fire && in_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && stage_fire && in_last_reg)
        begin
            out_kind_reg     <= kind_next;
            out_status_reg   <= status_next;
            out_station_reg  <= station_next;
            out_aircraft_reg <= (kind_next == hfcs_pkg::KIND_DOWNLINK) ? aircraft_next : 8'd0;
            out_count_reg    <= count_next;
            out_hend_reg     <= hend_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {3'd0, out_hend_reg, out_count_reg, out_aircraft_reg,
                            out_station_reg, out_status_reg};

endmodule

/* hw/rtl/hfcs_crc16_byte.sv */
module hfcs_crc16_byte
(
    input  logic [15:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [15:0] crc_out
);

    // Eight reflected shift steps folded into one byte-wide update.
    always_comb
    begin
        logic [15:0] c;
        c = crc_in ^ {8'd0, data_in};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ hfcs_pkg::FCS_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

/* hw/rtl/hfcs_port_checker.sv */
module hfcs_port_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // A held result keeps its contents until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
    else $error("result changed while stalled");

    // A fresh result follows a last byte accepted at the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
    else $error("result without a preceding last byte");

    // The input only stalls behind a held result.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled with the output free");

    // Only downlink frames carry an aircraft id; squitters carry no count.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != hfcs_pkg::KIND_DOWNLINK |->
            m_axis_tdata[16:9] == 8'd0
            && (m_axis_tuser != hfcs_pkg::KIND_SQUITTER || m_axis_tdata[20:17] == 4'd0))
    else $error("aircraft id or count on the wrong frame kind");

endmodule

bind hfdl_header_fcs_checker hfcs_port_checker u_port_checker (.*);
